// ----- rtl/acb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and constants for the anti-aliased circle blend block.
// No dependencies; the design modules refer to this package by scoped names.
package acb_pkg;

	// Parameter defaults
	localparam int COORD_FRAC_BITS_DEF  = 4;
	localparam int PIXEL_COORD_BITS_DEF = 11;

	// Fixed field widths
	localparam int CENTER_W   = 15;
	localparam int RADIUS_W   = 12;
	localparam int COLOR_W    = 24;
	localparam int ALPHA_W    = 8;
	localparam int CHAN_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Squared radius and its root
	localparam int R2_W           = 2 * RADIUS_W;
	localparam int ROOT_W         = RADIUS_W;
	localparam int SQRT_STEPS     = ROOT_W;
	localparam int SQRT_PER_STAGE = 2;
	localparam int SQRT_STAGES    = SQRT_STEPS / SQRT_PER_STAGE;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 3'd4;

	// Alpha codes
	localparam logic [ALPHA_W-1:0] ALPHA_NONE = 8'h00;
	localparam logic [ALPHA_W-1:0] ALPHA_FULL = 8'hFF;

	// Divide by three of a value below 2048: (v * 683) >> 11
	localparam int DIV3_MUL   = 683;
	localparam int DIV3_SHIFT = 11;
	localparam int DIV3_IN_W  = 10;

	typedef struct packed {
		logic [R2_W-1:0] rem;
		logic [R2_W-1:0] root;
	} sqrt_state_t;

	typedef struct packed {
		logic [R2_W-1:0]    d2;
		logic               in_circle;
		logic [COLOR_W-1:0] dest;
	} dist_beat_t;

	typedef struct packed {
		sqrt_state_t        st;
		logic               in_circle;
		logic [COLOR_W-1:0] dest;
	} sqrt_beat_t;

	typedef struct packed {
		logic [ROOT_W-1:0]  root;
		logic               in_circle;
		logic [COLOR_W-1:0] dest;
	} root_beat_t;

	typedef struct packed {
		logic [RADIUS_W-1:0] radius;
		logic [COLOR_W-1:0]  color;
		logic [ALPHA_W-1:0]  alpha;
	} shade_cfg_t;

	// One step of the digit-by-digit square root; step 0 handles the top bit pair
	function automatic sqrt_state_t sqrt_step(sqrt_state_t s, int unsigned k);
		logic [R2_W-1:0] bitv;
		logic [R2_W-1:0] trial;
		sqrt_state_t     r;
		bitv  = R2_W'(1) << (R2_W - 2 - 2 * k);
		trial = s.root + bitv;
		if (s.rem >= trial) begin
			r.rem  = s.rem - trial;
			r.root = (s.root >> 1) + bitv;
		end else begin
			r.rem  = s.rem;
			r.root = s.root >> 1;
		end
		return r;
	endfunction

endpackage

// ----- rtl/acb_pix_in_if.sv -----
`timescale 1ns / 1ps
// Input channel: pixel position and stored color, valid/ready handshake.
// No dependencies.
interface acb_pix_in_if #(
	parameter int PIX_W = 11
);
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_x;
	logic [PIX_W-1:0] pixel_y;
	logic [23:0]      dest_color;

	modport source (output valid, output pixel_x, output pixel_y, output dest_color,
		input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input dest_color,
		output ready);
endinterface

// ----- rtl/acb_pix_out_if.sv -----
`timescale 1ns / 1ps
// Output channel: blended color and inside flag, valid/ready handshake.
// No dependencies.
interface acb_pix_out_if;
	logic        valid;
	logic        ready;
	logic [23:0] out_color;
	logic        inside_res;

	modport source (output valid, output out_color, output inside_res, input ready);
	modport sink (input valid, input out_color, input inside_res, output ready);
endinterface

// ----- rtl/acb_dist.sv -----
`timescale 1ns / 1ps
// Squared-distance front end: offsets, squares, sum and inside test in three stages.
// Depends on acb_pkg.
module acb_dist #(
	parameter int COORD_FRAC_BITS  = acb_pkg::COORD_FRAC_BITS_DEF,
	parameter int PIXEL_COORD_BITS = acb_pkg::PIXEL_COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [PIXEL_COORD_BITS-1:0]       pixel_x,
	input  logic [PIXEL_COORD_BITS-1:0]       pixel_y,
	input  logic [acb_pkg::COLOR_W-1:0]       dest_color,
	input  logic [acb_pkg::CENTER_W-1:0]      center_x,
	input  logic [acb_pkg::CENTER_W-1:0]      center_y,
	input  logic [acb_pkg::RADIUS_W-1:0]      circle_radius,
	output logic                              out_valid,
	input  logic                              out_ready,
	output acb_pkg::dist_beat_t               out_beat
);
	localparam int PW  = PIXEL_COORD_BITS + COORD_FRAC_BITS;
	localparam int DW  = (PW > acb_pkg::CENTER_W) ? PW : acb_pkg::CENTER_W;
	localparam int QW  = 2 * DW;
	localparam int SW  = QW + 1;
	localparam int R2W = acb_pkg::R2_W;
	localparam int CW  = acb_pkg::COLOR_W;

	logic [DW-1:0]  px, py, cx, cy;
	logic [DW-1:0]  dx_s1, dy_s1;
	logic [CW-1:0]  dest_s1, dest_s2, dest_s3;
	logic [QW-1:0]  sqx_s2, sqy_s2;
	logic [SW-1:0]  sum;
	logic [R2W-1:0] d2_s3;
	logic           inside_s3;
	logic [R2W-1:0] r2_q;
	logic           valid_s1, valid_s2, valid_s3;
	logic           ready_s1, ready_s2, ready_s3;

	// Move pixel centers onto the fixed-point grid
	assign px = DW'(pixel_x) << COORD_FRAC_BITS;
	assign py = DW'(pixel_y) << COORD_FRAC_BITS;
	assign cx = DW'(center_x);
	assign cy = DW'(center_y);

	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// Track the squared radius; the user must change the radius only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r2_q <= '0;
		end else begin
			r2_q <= R2W'(circle_radius) * R2W'(circle_radius);
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// Stage 1: absolute offsets from the centre
	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			dx_s1   <= (px >= cx) ? (px - cx) : (cx - px);
			dy_s1   <= (py >= cy) ? (py - cy) : (cy - py);
			dest_s1 <= dest_color;
		end
	end

	// Stage 2: squares
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			sqx_s2  <= QW'(dx_s1) * QW'(dx_s1);
			sqy_s2  <= QW'(dy_s1) * QW'(dy_s1);
			dest_s2 <= dest_s1;
		end
	end

	// Stage 3: sum and inside test; the root is only used at or below the squared radius
	assign sum = SW'(sqx_s2) + SW'(sqy_s2);

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			d2_s3     <= sum[R2W-1:0];
			inside_s3 <= (sum <= SW'(r2_q));
			dest_s3   <= dest_s2;
		end
	end

	assign out_valid          = valid_s3;
	assign out_beat.d2        = d2_s3;
	assign out_beat.in_circle = inside_s3;
	assign out_beat.dest      = dest_s3;
endmodule

// ----- rtl/acb_sqrt.sv -----
`timescale 1ns / 1ps
// Pipelined integer square root of the squared distance, two result bits per stage.
// Depends on acb_pkg.
module acb_sqrt (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  acb_pkg::dist_beat_t  in_beat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output acb_pkg::root_beat_t  out_beat
);
	localparam int NS = acb_pkg::SQRT_STAGES;
	localparam int PS = acb_pkg::SQRT_PER_STAGE;

	acb_pkg::sqrt_beat_t beat_s  [NS];
	acb_pkg::sqrt_beat_t next_s  [NS];
	logic [NS-1:0]       valid_s;
	logic [NS-1:0]       ready_s;
	logic [NS-1:0]       feed_valid;
	acb_pkg::sqrt_beat_t head;

	// Start with the whole radicand as remainder
	assign head.st.rem    = in_beat.d2;
	assign head.st.root   = '0;
	assign head.in_circle = in_beat.in_circle;
	assign head.dest      = in_beat.dest;

	genvar g;
	generate
		for (g = 0; g < NS; g++) begin : g_stage
			acb_pkg::sqrt_beat_t src;

			if (g == 0) begin : g_first
				assign src           = head;
				assign feed_valid[g] = in_valid;
			end else begin : g_rest
				assign src           = beat_s[g-1];
				assign feed_valid[g] = valid_s[g-1];
			end

			if (g == NS - 1) begin : g_last
				assign ready_s[g] = !valid_s[g] || out_ready;
			end else begin : g_mid
				assign ready_s[g] = !valid_s[g] || ready_s[g+1];
			end

			// Two root bits per stage
			always_comb begin
				next_s[g] = src;
				for (int j = 0; j < PS; j++) begin
					next_s[g].st = acb_pkg::sqrt_step(next_s[g].st, g * PS + j);
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[g] <= 1'b0;
				end else if (ready_s[g]) begin
					valid_s[g] <= feed_valid[g];
				end
			end

			always_ff @(posedge clk) begin
				if (ready_s[g] && feed_valid[g]) begin
					beat_s[g] <= next_s[g];
				end
			end
		end
	endgenerate

	assign in_ready           = ready_s[0];
	assign out_valid          = valid_s[NS-1];
	assign out_beat.root      = beat_s[NS-1].st.root[acb_pkg::ROOT_W-1:0];
	assign out_beat.in_circle = beat_s[NS-1].in_circle;
	assign out_beat.dest      = beat_s[NS-1].dest;
endmodule

// ----- rtl/acb_blend.sv -----
`timescale 1ns / 1ps
// Edge falloff of alpha and per-channel blend over the stored color, four stages.
// Depends on acb_pkg.
module acb_blend #(
	parameter int COORD_FRAC_BITS = acb_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  acb_pkg::root_beat_t           in_beat,
	input  acb_pkg::shade_cfg_t           cfg,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [acb_pkg::COLOR_W-1:0]   out_color,
	output logic                          inside_res
);
	localparam int RW  = acb_pkg::RADIUS_W;
	localparam int GW  = RW + 1;
	localparam int AW  = acb_pkg::ALPHA_W;
	localparam int NW  = AW + GW;
	localparam int VW  = acb_pkg::DIV3_IN_W;
	localparam int MW  = VW + acb_pkg::DIV3_SHIFT - 1;
	localparam int KW  = acb_pkg::CHAN_W;
	localparam int BW  = 2 * KW;
	localparam int XW  = BW + 1;
	localparam int CW  = acb_pkg::COLOR_W;
	localparam logic [GW-1:0] SPAN = GW'(3 << COORD_FRAC_BITS);

	logic [GW-1:0] gap2;
	logic [VW-1:0] quot_in;
	logic [MW-1:0] quot_prod;
	logic [AW-1:0] a_inv;

	logic          valid_s1, valid_s2, valid_s3, valid_s4;
	logic          ready_s1, ready_s2, ready_s3, ready_s4;
	logic [NW-1:0] num_s1;
	logic          near_s1, inside_s1, inside_s2, inside_s4;
	logic [CW-1:0] dest_s1, dest_s2;
	logic [AW-1:0] alpha_s2;
	logic [BW-1:0] sum_s3 [3];
	logic [BW-1:0] sum_next [3];
	logic          pass_s3, full_s3, inside_s3;
	logic [CW-1:0] dest_s3;
	logic [CW-1:0] color_s4;
	logic [CW-1:0] mix;

	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// Stage 1: twice the gap to the rim, edge band test, alpha times gap
	assign gap2 = {cfg.radius - in_beat.root, 1'b0};

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			near_s1   <= (gap2 < SPAN);
			num_s1    <= NW'(cfg.alpha) * NW'(gap2);
			inside_s1 <= in_beat.in_circle;
			dest_s1   <= in_beat.dest;
		end
	end

	// Stage 2: divide by the band width; below it the quotient stays under 255
	assign quot_in   = VW'(num_s1 >> COORD_FRAC_BITS);
	assign quot_prod = MW'(quot_in) * MW'(acb_pkg::DIV3_MUL);

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			alpha_s2  <= near_s1 ? AW'(quot_prod >> acb_pkg::DIV3_SHIFT) : cfg.alpha;
			inside_s2 <= inside_s1;
			dest_s2   <= dest_s1;
		end
	end

	// Stage 3: weighted sums per channel
	assign a_inv = acb_pkg::ALPHA_FULL - alpha_s2;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_next[c] = BW'(cfg.color[c*KW +: KW]) * BW'(alpha_s2)
				+ BW'(dest_s2[c*KW +: KW]) * BW'(a_inv);
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			sum_s3    <= sum_next;
			pass_s3   <= !inside_s2 || (alpha_s2 == acb_pkg::ALPHA_NONE);
			full_s3   <= (alpha_s2 == acb_pkg::ALPHA_FULL);
			inside_s3 <= inside_s2;
			dest_s3   <= dest_s2;
		end
	end

	// Stage 4: divide by 255 as (x + 1 + (x >> 8)) >> 8, then pick the result
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			mix[c*KW +: KW] = KW'((XW'(sum_s3[c]) + XW'(1) + XW'(sum_s3[c] >> KW)) >> KW);
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			priority if (pass_s3) begin
				color_s4 <= dest_s3;
			end else if (full_s3) begin
				color_s4 <= cfg.color;
			end else begin
				color_s4 <= mix;
			end
			inside_s4 <= inside_s3;
		end
	end

	assign out_valid  = valid_s4;
	assign out_color  = color_s4;
	assign inside_res = inside_s4;
endmodule

// ----- rtl/antialiased_circle_blend_top.sv -----
`timescale 1ns / 1ps
// Top level of the anti-aliased circle blend shader: configuration registers and pipeline.
// Depends on acb_pkg, acb_pix_in_if, acb_pix_out_if, acb_dist, acb_sqrt, acb_blend.
//
// Usage:
//   pix_in carries one pixel per beat: integer pixel_x, pixel_y and the stored dest_color.
//   pix_out returns one beat per input beat, in order: the blended out_color and
//   inside_res, set when the pixel lies on or within the circle radius.
//   Configuration is a write port (cfg_we, cfg_index, cfg_data); index 0 centre x,
//   1 centre y, 2 radius, 3 fill color, 4 fill alpha; other indexes are dropped.
//   Write it only while no pixel is in flight.
// Pipeline and throughput:
//   Path of an accepted input beat: 3 distance stages, 6 square-root stages of two
//   root bits each, 4 alpha and blend stages. One pixel per cycle while pix_out.ready
//   is high; every stage is a registered step with its own valid.
// Reset:
//   arst_n clears all valid bits and the registers: centre, radius and color to zero,
//   fill alpha to 255. No clearing pass; pix_in.ready is high as soon as reset is released.
// Stalls:
//   When pix_out.ready is low, stages close up bubbles and then hold; pix_in.ready
//   drops only once every stage is full. No beat is lost or repeated.
module antialiased_circle_blend_top #(
	parameter int COORD_FRAC_BITS  = acb_pkg::COORD_FRAC_BITS_DEF,
	parameter int PIXEL_COORD_BITS = acb_pkg::PIXEL_COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [acb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [acb_pkg::CFG_DATA_W-1:0]    cfg_data,
	acb_pix_in_if.sink                        pix_in,
	acb_pix_out_if.source                     pix_out
);
	logic [acb_pkg::CENTER_W-1:0] center_x_q;
	logic [acb_pkg::CENTER_W-1:0] center_y_q;
	logic [acb_pkg::RADIUS_W-1:0] radius_q;
	logic [acb_pkg::COLOR_W-1:0]  color_q;
	logic [acb_pkg::ALPHA_W-1:0]  alpha_q;

	acb_pkg::shade_cfg_t  shade_cfg;
	acb_pkg::dist_beat_t  dist_beat;
	acb_pkg::root_beat_t  root_beat;
	logic                 dist_valid, dist_ready;
	logic                 root_valid, root_ready;

	// Capture register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q   <= '0;
			color_q    <= '0;
			alpha_q    <= acb_pkg::ALPHA_FULL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				acb_pkg::CFG_CENTER_X: center_x_q <= cfg_data[acb_pkg::CENTER_W-1:0];
				acb_pkg::CFG_CENTER_Y: center_y_q <= cfg_data[acb_pkg::CENTER_W-1:0];
				acb_pkg::CFG_RADIUS:   radius_q   <= cfg_data[acb_pkg::RADIUS_W-1:0];
				acb_pkg::CFG_COLOR:    color_q    <= cfg_data[acb_pkg::COLOR_W-1:0];
				acb_pkg::CFG_ALPHA:    alpha_q    <= cfg_data[acb_pkg::ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	assign shade_cfg.radius = radius_q;
	assign shade_cfg.color  = color_q;
	assign shade_cfg.alpha  = alpha_q;

	acb_dist #(
		.COORD_FRAC_BITS  (COORD_FRAC_BITS),
		.PIXEL_COORD_BITS (PIXEL_COORD_BITS)
	) u_dist (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (pix_in.valid),
		.in_ready      (pix_in.ready),
		.pixel_x       (pix_in.pixel_x),
		.pixel_y       (pix_in.pixel_y),
		.dest_color    (pix_in.dest_color),
		.center_x      (center_x_q),
		.center_y      (center_y_q),
		.circle_radius (radius_q),
		.out_valid     (dist_valid),
		.out_ready     (dist_ready),
		.out_beat      (dist_beat)
	);

	acb_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dist_valid),
		.in_ready  (dist_ready),
		.in_beat   (dist_beat),
		.out_valid (root_valid),
		.out_ready (root_ready),
		.out_beat  (root_beat)
	);

	acb_blend #(
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_blend (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (root_valid),
		.in_ready   (root_ready),
		.in_beat    (root_beat),
		.cfg        (shade_cfg),
		.out_valid  (pix_out.valid),
		.out_ready  (pix_out.ready),
		.out_color  (pix_out.out_color),
		.inside_res (pix_out.inside_res)
	);
endmodule
